>>> hw/rtl/trds_pkg.sv
// ----------------------------------------------------------------------------
// trds_pkg
// Codes, register indexes and frame lengths shared by the trace ring drain
// scheduler.
// ----------------------------------------------------------------------------
package trds_pkg;

  localparam int OP_W   = 3;
  localparam int TYPE_W = 2;
  localparam int FB_W   = 5;
  localparam int BUD_W  = 5;
  localparam int SPC_W  = 12;
  localparam int TS_W   = 32;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OP_W-1:0] OP_SERV  = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [TYPE_W-1:0] TYPE_MONITOR = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_BEGIN   = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_END     = 2'd2;

  localparam logic [CFG_IW-1:0] REG_RUN_IVL  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_STOP_IVL = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MON_IVL  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_RUN_HI   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_RUN_LO   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_IDLE_HI  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_IDLE_LO  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_DEFAULT  = 3'd7;

  localparam logic [BUD_W-1:0] MAX_PASS = 5'd16;

  localparam logic [FB_W-1:0] FB_MONITOR = 5'd16;
  localparam logic [FB_W-1:0] FB_BEGIN   = 5'd14;
  localparam logic [FB_W-1:0] FB_END     = 5'd20;
  localparam logic [FB_W-1:0] FB_OTHER   = 5'd0;

  function automatic logic [FB_W-1:0] frame_size(input logic [TYPE_W-1:0] t);
    logic [FB_W-1:0] fb;
    unique case (t)
      TYPE_MONITOR: fb = FB_MONITOR;
      TYPE_BEGIN:   fb = FB_BEGIN;
      TYPE_END:     fb = FB_END;
      default:      fb = FB_OTHER;
    endcase
    return fb;
  endfunction

endpackage

>>> hw/rtl/trace_ring_drain_scheduler.sv
// ----------------------------------------------------------------------------
// trace_ring_drain_scheduler
// Overwrite-oldest trace ring with a rate-limited, budgeted drain.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge with start high and busy low. Push
// stores a typed record, tick advances the millisecond counter, service runs
// a drain pass when its interval has passed, flush runs a pass of sixteen and
// clear empties the ring. Each command ends with one status word (last high);
// a pass emits its trace words before that. Every result word is shown on
// the result ports for one cycle with strobe high; the receiver cannot stall
// it, so there is no back-pressure on the result side.
// A command that runs no pass goes from idle straight to ST_STATUS, and busy
// falls in the cycle the status word is shown. A pass examines each ring
// entry in ST_CHECK, which does the ring memory read, and then in ST_EVAL,
// which judges the entry; it closes through ST_STATUS, which gives the status
// word. A full pass examines sixteen entries. The registered memory read
// port is why the read and the judging lie in separate states.
// Reset clears the control state and loads the register reset values; the
// ring memory holds no reset value and needs no clearing.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user is
// to write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module trace_ring_drain_scheduler #(
  parameter int RING_DEPTH   = 256,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [trds_pkg::OP_W-1:0]              op,
  input  logic [trds_pkg::TYPE_W-1:0]            item_type,
  input  logic [PAYLOAD_BITS-1:0]                item_payload,
  input  logic                                   running,
  input  logic                                   stage_idle,
  input  logic [trds_pkg::SPC_W-1:0]             tx_space,
  input  logic                                   cfg_we,
  input  logic [trds_pkg::CFG_IW-1:0]            cfg_index,
  input  logic [trds_pkg::CFG_DW-1:0]            cfg_data,
  output logic                                   strobe,
  output logic                                   kind,
  output logic [trds_pkg::TYPE_W-1:0]            out_type,
  output logic [PAYLOAD_BITS-1:0]                out_payload,
  output logic [trds_pkg::FB_W-1:0]              frame_bytes,
  output logic [$clog2(RING_DEPTH):0]            pending_count,
  output logic                                   busy_res,
  output logic [31:0]                            overflow_count,
  output logic                                   last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = AW + 1;
  localparam int MW = trds_pkg::TYPE_W + PAYLOAD_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);
  localparam logic [CW-1:0] HALF_CNT = CW'(RING_DEPTH / 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_STATUS
  } state_t;

  state_t state;

  logic [MW-1:0] ring_mem [RING_DEPTH];
  logic [MW-1:0] rd_data;

  logic [7:0]  run_ivl;
  logic [7:0]  stop_ivl;
  logic [15:0] mon_ivl;
  logic [trds_pkg::BUD_W-1:0] run_hi;
  logic [trds_pkg::BUD_W-1:0] run_lo;
  logic [trds_pkg::BUD_W-1:0] idle_hi;
  logic [trds_pkg::BUD_W-1:0] idle_lo;
  logic [trds_pkg::BUD_W-1:0] def_budget;

  logic [AW-1:0] write_index;
  logic [AW-1:0] read_index;
  logic [CW-1:0] held_count;
  logic          pending_flag;
  logic [31:0]   overflow_total;
  logic [trds_pkg::TS_W-1:0] now_ms;
  logic [trds_pkg::TS_W-1:0] last_drain_ms;
  logic [trds_pkg::TS_W-1:0] last_monitor_ms;

  logic [trds_pkg::BUD_W-1:0] budget;
  logic [trds_pkg::BUD_W-1:0] done_cnt;
  logic [trds_pkg::SPC_W-1:0] space;
  logic                       mon_allowed;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] write_index_next;
  logic [AW-1:0] read_index_next;
  logic [7:0]    drain_ivl;
  logic          drain_ok;
  logic          mon_ok;
  logic          ring_half;
  logic [trds_pkg::BUD_W-1:0] raw_budget;
  logic [trds_pkg::BUD_W-1:0] sat_budget;
  logic [trds_pkg::TYPE_W-1:0] ent_type;
  logic [trds_pkg::FB_W-1:0]   ent_fb;
  logic                        no_fit;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (op == trds_pkg::OP_PUSH);

  always_comb begin
    write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
    read_index_next  = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
    drain_ivl = running ? run_ivl : stop_ivl;
    drain_ok  = (last_drain_ms == '0) ||
                ((now_ms - last_drain_ms) >= {24'd0, drain_ivl});
    mon_ok    = (last_monitor_ms == '0) ||
                ((now_ms - last_monitor_ms) >= {16'd0, mon_ivl});
    ring_half = held_count > HALF_CNT;
    if (running) begin
      raw_budget = ring_half ? run_hi : run_lo;
    end else if (stage_idle) begin
      raw_budget = ring_half ? idle_hi : idle_lo;
    end else begin
      raw_budget = def_budget;
    end
    sat_budget = (raw_budget > trds_pkg::MAX_PASS) ? trds_pkg::MAX_PASS : raw_budget;
    ent_type = rd_data[MW-1:PAYLOAD_BITS];
    ent_fb   = trds_pkg::frame_size(ent_type);
    no_fit   = space < {{(trds_pkg::SPC_W - trds_pkg::FB_W){1'b0}}, ent_fb};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[write_index] <= {item_type, item_payload};
    end
    if (state == ST_CHECK) begin
      rd_data <= ring_mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_ivl    <= 8'd2;
      stop_ivl   <= 8'd5;
      mon_ivl    <= 16'd100;
      run_hi     <= 5'd12;
      run_lo     <= 5'd6;
      idle_hi    <= 5'd10;
      idle_lo    <= 5'd5;
      def_budget <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trds_pkg::REG_RUN_IVL:  run_ivl    <= cfg_data[7:0];
        trds_pkg::REG_STOP_IVL: stop_ivl   <= cfg_data[7:0];
        trds_pkg::REG_MON_IVL:  mon_ivl    <= cfg_data;
        trds_pkg::REG_RUN_HI:   run_hi     <= cfg_data[trds_pkg::BUD_W-1:0];
        trds_pkg::REG_RUN_LO:   run_lo     <= cfg_data[trds_pkg::BUD_W-1:0];
        trds_pkg::REG_IDLE_HI:  idle_hi    <= cfg_data[trds_pkg::BUD_W-1:0];
        trds_pkg::REG_IDLE_LO:  idle_lo    <= cfg_data[trds_pkg::BUD_W-1:0];
        default:                def_budget <= cfg_data[trds_pkg::BUD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_index     <= '0;
      read_index      <= '0;
      held_count      <= '0;
      pending_flag    <= 1'b0;
      overflow_total  <= '0;
      now_ms          <= '0;
      last_drain_ms   <= '0;
      last_monitor_ms <= '0;
      strobe          <= 1'b0;
      budget          <= '0;
      done_cnt        <= '0;
      space           <= '0;
      mon_allowed     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state       <= ST_STATUS;
            done_cnt    <= '0;
            space       <= tx_space;
            mon_allowed <= 1'b1;
            budget      <= trds_pkg::MAX_PASS;
            unique case (op)
              trds_pkg::OP_PUSH: begin
                write_index  <= write_index_next;
                pending_flag <= 1'b1;
                if (held_count < FULL_CNT) begin
                  held_count <= held_count + 1'b1;
                end else begin
                  read_index     <= read_index_next;
                  overflow_total <= overflow_total + 1'b1;
                end
              end
              trds_pkg::OP_TICK: begin
                now_ms <= now_ms + 1'b1;
              end
              trds_pkg::OP_SERV: begin
                if (pending_flag && drain_ok) begin
                  last_drain_ms <= now_ms;
                  budget        <= sat_budget;
                  state         <= ST_CHECK;
                  if (running) begin
                    mon_allowed <= mon_ok;
                    if (mon_ok) begin
                      last_monitor_ms <= now_ms;
                    end
                  end
                end
              end
              trds_pkg::OP_FLUSH: begin
                state <= ST_CHECK;
              end
              trds_pkg::OP_CLEAR: begin
                write_index    <= '0;
                read_index     <= '0;
                held_count     <= '0;
                pending_flag   <= 1'b0;
                overflow_total <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (done_cnt >= budget) begin
            state <= ST_STATUS;
          end else if (held_count == '0) begin
            pending_flag <= 1'b0;
            state        <= ST_STATUS;
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if ((ent_type == trds_pkg::TYPE_BEGIN || ent_type == trds_pkg::TYPE_END)
              && no_fit) begin
            state <= ST_STATUS;
          end else begin
            read_index   <= read_index_next;
            held_count   <= held_count - 1'b1;
            pending_flag <= (held_count != CW'(1));
            done_cnt     <= done_cnt + 1'b1;
            state        <= ST_CHECK;
            if (!(ent_type == trds_pkg::TYPE_MONITOR && (!mon_allowed || no_fit))) begin
              space          <= space - {{(trds_pkg::SPC_W - trds_pkg::FB_W){1'b0}}, ent_fb};
              strobe         <= 1'b1;
              kind           <= 1'b0;
              last           <= 1'b0;
              out_type       <= ent_type;
              out_payload    <= rd_data[PAYLOAD_BITS-1:0];
              frame_bytes    <= ent_fb;
              pending_count  <= held_count - 1'b1;
              busy_res       <= (held_count != CW'(1));
              overflow_count <= overflow_total;
            end
          end
        end
        ST_STATUS: begin
          state          <= ST_IDLE;
          strobe         <= 1'b1;
          kind           <= 1'b1;
          last           <= 1'b1;
          out_type       <= '0;
          out_payload    <= '0;
          frame_bytes    <= '0;
          pending_count  <= held_count;
          busy_res       <= pending_flag || (held_count != '0);
          overflow_count <= overflow_total;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL_CNT)
    else $error("ring fill count exceeds the ring depth");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    strobe |-> pending_count == held_count)
    else $error("result word fill count disagrees with the ring");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command left the block idle");

  a_trace_not_final: assert property (@(posedge clk) disable iff (rst)
    (strobe && !kind) |-> busy)
    else $error("trace word shown without a status word to follow");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trace ring drain scheduler. Command words are
// driven back to back or with random gaps, and every result word is compared
// field by field with a behavioural prediction of the ring, its drain passes
// and its interval stamps. The block is taken through several register
// settings, the extremes among them, and bursts of pushes are drained.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RING  = 256;
  localparam int PAY_W = 64;
  localparam int LIMIT = 400000;

  typedef logic [trds_pkg::OP_W-1:0]   op_t;
  typedef logic [trds_pkg::TYPE_W-1:0] item_t;
  typedef logic [trds_pkg::SPC_W-1:0]  space_t;
  typedef logic [trds_pkg::FB_W-1:0]   frame_t;
  typedef logic [trds_pkg::CFG_DW-1:0] cfg_word_t;
  typedef logic [trds_pkg::CFG_IW-1:0] cfg_index_t;

  localparam item_t TYPE_OTHER  = 2'd3;
  localparam op_t   OP_RSVD_LO  = 3'd5;
  localparam op_t   OP_RSVD_HI  = 3'd7;
  localparam logic  KIND_TRACE  = 1'b0;
  localparam logic  KIND_STATUS = 1'b1;

  typedef struct {
    logic             kind;
    item_t            out_type;
    logic [PAY_W-1:0] payload;
    frame_t           frame;
    logic [8:0]       count;
    logic             busy_res;
    logic [31:0]      overflow;
    logic             last;
  } result_word_t;

  class ring_scoreboard;
    result_word_t     words_due[$];
    int               errors;
    cfg_word_t        regs[8];
    item_t            kept_type[RING];
    logic [PAY_W-1:0] kept_payload[RING];
    logic [7:0]       wr_ptr;
    logic [7:0]       rd_ptr;
    logic [8:0]       held;
    logic             pend;
    logic [31:0]      overflow_total;
    logic [31:0]      now_ms;
    logic [31:0]      last_drain_ms;
    logic [31:0]      last_monitor_ms;

    function void power_up();
      regs[trds_pkg::REG_RUN_IVL]  = 16'd2;
      regs[trds_pkg::REG_STOP_IVL] = 16'd5;
      regs[trds_pkg::REG_MON_IVL]  = 16'd100;
      regs[trds_pkg::REG_RUN_HI]   = 16'd12;
      regs[trds_pkg::REG_RUN_LO]   = 16'd6;
      regs[trds_pkg::REG_IDLE_HI]  = 16'd10;
      regs[trds_pkg::REG_IDLE_LO]  = 16'd5;
      regs[trds_pkg::REG_DEFAULT]  = 16'd4;
      wr_ptr          = '0;
      rd_ptr          = '0;
      held            = '0;
      pend            = 1'b0;
      overflow_total  = '0;
      now_ms          = '0;
      last_drain_ms   = '0;
      last_monitor_ms = '0;
      errors          = 0;
    endfunction

    function int due();
      return words_due.size();
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare(input string field, input logic [63:0] got, input logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", field, got, want));
    endtask

    function void set_reg(input cfg_index_t idx, input cfg_word_t data);
      case (idx)
        trds_pkg::REG_RUN_IVL, trds_pkg::REG_STOP_IVL: regs[idx] = data & 16'h00FF;
        trds_pkg::REG_MON_IVL:                         regs[idx] = data;
        default:                                       regs[idx] = data & 16'h001F;
      endcase
    endfunction

    function frame_t frame_of(input item_t t);
      case (t)
        trds_pkg::TYPE_MONITOR: return trds_pkg::FB_MONITOR;
        trds_pkg::TYPE_BEGIN:   return trds_pkg::FB_BEGIN;
        trds_pkg::TYPE_END:     return trds_pkg::FB_END;
        default:                return trds_pkg::FB_OTHER;
      endcase
    endfunction

    function void add_word(input logic k, input item_t t, input logic [PAY_W-1:0] p,
                           input frame_t fb);
      result_word_t w;
      w.kind     = k;
      w.out_type = t;
      w.payload  = p;
      w.frame    = fb;
      w.count    = held;
      w.busy_res = pend || (held != 0);
      w.overflow = overflow_total;
      w.last     = k;
      words_due.push_back(w);
    endfunction

    function void pop_oldest();
      rd_ptr++;
      held--;
      pend = (held != 0);
    endfunction

    // The budget counts dropped words as well as emitted ones.
    function void drain_pass(input cfg_word_t budget, input logic allow, input space_t space);
      int               limit;
      int               used;
      item_t            t;
      logic [PAY_W-1:0] p;
      frame_t           fb;
      limit = (budget > cfg_word_t'(trds_pkg::MAX_PASS)) ? int'(trds_pkg::MAX_PASS)
                                                         : int'(budget);
      used  = 0;
      while (used < limit) begin
        if (held == 0) begin
          pend = 1'b0;
          break;
        end
        t  = kept_type[rd_ptr];
        p  = kept_payload[rd_ptr];
        fb = frame_of(t);
        if (t == trds_pkg::TYPE_MONITOR && !allow) begin
          pop_oldest();
          used++;
          continue;
        end
        if ((t == trds_pkg::TYPE_BEGIN || t == trds_pkg::TYPE_END) && space < fb) break;
        if (t == trds_pkg::TYPE_MONITOR && space < fb) begin
          pop_oldest();
          used++;
          continue;
        end
        pop_oldest();
        space = space - fb;
        add_word(KIND_TRACE, t, p, fb);
        used++;
      end
    endfunction

    function void note_command(input op_t c, input item_t t, input logic [PAY_W-1:0] p,
                               input logic run, input logic idle, input space_t space);
      cfg_word_t   ivl;
      cfg_word_t   budget;
      logic [31:0] since;
      logic        allow;
      logic        half;
      case (c)
        trds_pkg::OP_PUSH: begin
          kept_type[wr_ptr]    = t;
          kept_payload[wr_ptr] = p;
          wr_ptr++;
          if (held < RING) begin
            held++;
          end else begin
            rd_ptr++;
            overflow_total++;
          end
          pend = 1'b1;
        end
        trds_pkg::OP_TICK: now_ms++;
        trds_pkg::OP_SERV: begin
          ivl   = run ? regs[trds_pkg::REG_RUN_IVL] : regs[trds_pkg::REG_STOP_IVL];
          since = now_ms - last_drain_ms;
          if (pend && (last_drain_ms == 0 || since >= ivl)) begin
            allow  = 1'b1;
            half   = held > RING / 2;
            budget = regs[trds_pkg::REG_DEFAULT];
            if (run) begin
              since = now_ms - last_monitor_ms;
              allow = (last_monitor_ms == 0) || (since >= regs[trds_pkg::REG_MON_IVL]);
              if (allow) last_monitor_ms = now_ms;
              budget = half ? regs[trds_pkg::REG_RUN_HI] : regs[trds_pkg::REG_RUN_LO];
            end else if (idle) begin
              budget = half ? regs[trds_pkg::REG_IDLE_HI] : regs[trds_pkg::REG_IDLE_LO];
            end
            last_drain_ms = now_ms;
            drain_pass(budget, allow, space);
          end
        end
        trds_pkg::OP_FLUSH: drain_pass(cfg_word_t'(trds_pkg::MAX_PASS), 1'b1, space);
        trds_pkg::OP_CLEAR: begin
          wr_ptr         = '0;
          rd_ptr         = '0;
          held           = '0;
          pend           = 1'b0;
          overflow_total = '0;
        end
        default: ;
      endcase
      add_word(KIND_STATUS, '0, '0, '0);
    endfunction

    task check_word(input logic k, input item_t t, input logic [PAY_W-1:0] p,
                    input frame_t fb, input logic [8:0] cnt, input logic br,
                    input logic [31:0] ovf, input logic lst);
      result_word_t want;
      if (words_due.size() == 0) begin
        report($sformatf("result word of kind %0d with nothing due", k));
      end else begin
        want = words_due.pop_front();
        compare("kind", 64'(k), 64'(want.kind));
        compare("out_type", 64'(t), 64'(want.out_type));
        compare("out_payload", 64'(p), 64'(want.payload));
        compare("frame_bytes", 64'(fb), 64'(want.frame));
        compare("pending_count", 64'(cnt), 64'(want.count));
        compare("busy_res", 64'(br), 64'(want.busy_res));
        compare("overflow_count", 64'(ovf), 64'(want.overflow));
        compare("last", 64'(lst), 64'(want.last));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  op_t              op = '0;
  item_t            item_type = '0;
  logic [PAY_W-1:0] item_payload = '0;
  logic             running = 1'b0;
  logic             stage_idle = 1'b0;
  space_t           tx_space = '0;
  logic             cfg_we = 1'b0;
  cfg_index_t       cfg_index = '0;
  cfg_word_t        cfg_data = '0;
  logic             busy;
  logic             strobe;
  logic             kind;
  item_t            out_type;
  logic [PAY_W-1:0] out_payload;
  frame_t           frame_bytes;
  logic [8:0]       pending_count;
  logic             busy_res;
  logic [31:0]      overflow_count;
  logic             last;
  int               cycles = 0;
  ring_scoreboard   sb;

  trace_ring_drain_scheduler dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_word(kind, out_type, out_payload, frame_bytes, pending_count, busy_res,
                    overflow_count, last);
    end
  end

  // Leaves start high, so that a following word can go out without a gap.
  task automatic send_command(input op_t c, input item_t t, input logic [PAY_W-1:0] p,
                              input logic r, input logic i, input space_t s);
    op           <= c;
    item_type    <= t;
    item_payload <= p;
    running      <= r;
    stage_idle   <= i;
    tx_space     <= s;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(c, t, p, r, i, s);
  endtask

  task automatic send_push(input item_t t, input logic [PAY_W-1:0] p);
    send_command(trds_pkg::OP_PUSH, t, p, 1'($urandom), 1'($urandom), space_t'($urandom));
  endtask

  task automatic send_random();
    int     pick;
    op_t    c;
    space_t s;
    pick = $urandom_range(0, 99);
    if (pick < 40) c = trds_pkg::OP_PUSH;
    else if (pick < 58) c = trds_pkg::OP_TICK;
    else if (pick < 86) c = trds_pkg::OP_SERV;
    else if (pick < 93) c = trds_pkg::OP_FLUSH;
    else if (pick < 96) c = trds_pkg::OP_CLEAR;
    else c = op_t'($urandom_range(int'(OP_RSVD_LO), int'(OP_RSVD_HI)));
    s = ($urandom_range(0, 3) == 0) ? space_t'($urandom) : space_t'($urandom_range(0, 80));
    send_command(c, item_t'($urandom), {$urandom, $urandom}, 1'($urandom), 1'($urandom), s);
  endtask

  task automatic run_phase(input int count, input bit gaps);
    for (int n = 0; n < count; n++) begin
      if (gaps && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      send_random();
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.due() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_word_t vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_index_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_word_t setting [8];
    sb = new();
    sb.power_up();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words, run with the register reset values.
    send_command(trds_pkg::OP_SERV, TYPE_OTHER, '0, 1'b1, 1'b0, '1);
    send_push(trds_pkg::TYPE_MONITOR, '1);
    send_push(trds_pkg::TYPE_BEGIN, '0);
    send_push(trds_pkg::TYPE_END, {$urandom, $urandom});
    send_push(TYPE_OTHER, {$urandom, $urandom});
    send_command(trds_pkg::OP_FLUSH, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0, '1);
    for (int c = int'(OP_RSVD_LO); c <= int'(OP_RSVD_HI); c++) begin
      send_command(op_t'(c), trds_pkg::TYPE_END, '1, 1'b1, 1'b1, '1);
    end
    send_push(trds_pkg::TYPE_BEGIN, {$urandom, $urandom});
    send_push(trds_pkg::TYPE_END, {$urandom, $urandom});
    send_command(trds_pkg::OP_FLUSH, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0, '0);
    send_command(trds_pkg::OP_FLUSH, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0,
                 space_t'(trds_pkg::FB_BEGIN));
    send_command(trds_pkg::OP_FLUSH, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0,
                 space_t'(trds_pkg::FB_END));
    send_push(trds_pkg::TYPE_MONITOR, {$urandom, $urandom});
    send_push(TYPE_OTHER, {$urandom, $urandom});
    send_command(trds_pkg::OP_FLUSH, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0,
                 space_t'(trds_pkg::FB_MONITOR - 1'b1));
    send_command(trds_pkg::OP_TICK, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0, '0);
    send_push(trds_pkg::TYPE_MONITOR, {$urandom, $urandom});
    send_command(trds_pkg::OP_SERV, trds_pkg::TYPE_MONITOR, '0, 1'b1, 1'b0, '1);
    send_push(trds_pkg::TYPE_MONITOR, {$urandom, $urandom});
    send_command(trds_pkg::OP_SERV, trds_pkg::TYPE_MONITOR, '0, 1'b1, 1'b0, '1);
    send_command(trds_pkg::OP_TICK, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0, '0);
    send_command(trds_pkg::OP_TICK, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0, '0);
    send_command(trds_pkg::OP_SERV, trds_pkg::TYPE_MONITOR, '0, 1'b1, 1'b0, '1);
    send_push(trds_pkg::TYPE_END, {$urandom, $urandom});
    send_command(trds_pkg::OP_SERV, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b1, '1);
    send_command(trds_pkg::OP_CLEAR, trds_pkg::TYPE_MONITOR, '0, 1'b0, 1'b0, '0);
    settle();

    setting[trds_pkg::REG_RUN_IVL]  = cfg_word_t'($urandom_range(1, 4));
    setting[trds_pkg::REG_STOP_IVL] = cfg_word_t'($urandom_range(1, 6));
    setting[trds_pkg::REG_MON_IVL]  = cfg_word_t'($urandom_range(1, 20));
    setting[trds_pkg::REG_RUN_HI]   = cfg_word_t'($urandom_range(1, 16));
    setting[trds_pkg::REG_RUN_LO]   = cfg_word_t'($urandom_range(1, 16));
    setting[trds_pkg::REG_IDLE_HI]  = cfg_word_t'($urandom_range(1, 16));
    setting[trds_pkg::REG_IDLE_LO]  = cfg_word_t'($urandom_range(1, 16));
    setting[trds_pkg::REG_DEFAULT]  = cfg_word_t'($urandom_range(1, 16));
    load_regs(setting);
    run_phase(24, 1'b1);
    settle();

    // Zero intervals, with a burst of pushes drained afterwards.
    setting[trds_pkg::REG_RUN_IVL]  = 16'd0;
    setting[trds_pkg::REG_STOP_IVL] = 16'd0;
    setting[trds_pkg::REG_MON_IVL]  = 16'd0;
    setting[trds_pkg::REG_RUN_HI]   = 16'd16;
    setting[trds_pkg::REG_RUN_LO]   = 16'd3;
    setting[trds_pkg::REG_IDLE_HI]  = 16'd14;
    setting[trds_pkg::REG_IDLE_LO]  = 16'd2;
    setting[trds_pkg::REG_DEFAULT]  = 16'd7;
    load_regs(setting);
    for (int n = 0; n < 20; n++) send_push(item_t'($urandom), {$urandom, $urandom});
    run_phase(20, 1'b1);
    settle();

    // Widest stop and monitor intervals, and budgets of zero and beyond sixteen.
    setting[trds_pkg::REG_RUN_IVL]  = 16'd1;
    setting[trds_pkg::REG_STOP_IVL] = 16'h00FF;
    setting[trds_pkg::REG_MON_IVL]  = 16'hFFFF;
    setting[trds_pkg::REG_RUN_HI]   = 16'd31;
    setting[trds_pkg::REG_RUN_LO]   = 16'd0;
    setting[trds_pkg::REG_IDLE_HI]  = 16'd0;
    setting[trds_pkg::REG_IDLE_LO]  = 16'd31;
    setting[trds_pkg::REG_DEFAULT]  = 16'd0;
    load_regs(setting);
    for (int n = 0; n < 10; n++) send_push(item_t'($urandom), {$urandom, $urandom});
    run_phase(15, 1'b1);
    settle();

    setting[trds_pkg::REG_RUN_IVL]  = cfg_word_t'($urandom_range(0, 3));
    setting[trds_pkg::REG_STOP_IVL] = cfg_word_t'($urandom_range(0, 3));
    setting[trds_pkg::REG_MON_IVL]  = cfg_word_t'($urandom_range(0, 5));
    setting[trds_pkg::REG_RUN_HI]   = cfg_word_t'($urandom_range(0, 20));
    setting[trds_pkg::REG_RUN_LO]   = cfg_word_t'($urandom_range(0, 20));
    setting[trds_pkg::REG_IDLE_HI]  = cfg_word_t'($urandom_range(0, 20));
    setting[trds_pkg::REG_IDLE_LO]  = cfg_word_t'($urandom_range(0, 20));
    setting[trds_pkg::REG_DEFAULT]  = cfg_word_t'($urandom_range(0, 20));
    load_regs(setting);
    run_phase(15, 1'b0);
    settle();
    repeat (40) @(posedge clk);

    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
